// ===== hw/rtl/hklc_pkg.sv =====
// Shared types, constants and register codes of the hotkey level controller.
`timescale 1ns / 1ps

package hklc_pkg;

    localparam int CODE_W   = 10;
    localparam int VOL_W    = 5;
    localparam int BRIGHT_W = 4;
    localparam int HELD_W   = 4;
    localparam int REG_IDX_W = 3;
    localparam int CFG_DATA_W = CODE_W;

    localparam int VOLUME_MAX     = 20;
    localparam int BRIGHTNESS_MAX = 10;
    localparam int HELD_MAX       = 15;

    // Default key codes
    localparam logic [CODE_W-1:0] DEF_SELECT_KEY = CODE_W'(97);
    localparam logic [CODE_W-1:0] DEF_START_KEY  = CODE_W'(28);
    localparam logic [CODE_W-1:0] DEF_DOWN_KEY_A = CODE_W'(18);
    localparam logic [CODE_W-1:0] DEF_DOWN_KEY_B = CODE_W'(15);
    localparam logic [CODE_W-1:0] DEF_UP_KEY_A   = CODE_W'(20);
    localparam logic [CODE_W-1:0] DEF_UP_KEY_B   = CODE_W'(14);

    localparam logic [VOL_W-1:0]    VOLUME_RESET     = VOL_W'(10);
    localparam logic [BRIGHT_W-1:0] BRIGHTNESS_RESET = BRIGHT_W'(5);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SELECT_KEY         = 3'd0,
        REG_START_KEY          = 3'd1,
        REG_DOWN_KEY_A         = 3'd2,
        REG_DOWN_KEY_B         = 3'd3,
        REG_UP_KEY_A           = 3'd4,
        REG_UP_KEY_B           = 3'd5,
        REG_INITIAL_VOLUME     = 3'd6,
        REG_INITIAL_BRIGHTNESS = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        KV_RELEASE = 2'd0,
        KV_PRESS   = 2'd1,
        KV_REPEAT  = 2'd2,
        KV_OTHER   = 2'd3
    } key_value_t;

    typedef struct packed {
        logic [CODE_W-1:0] select_key;
        logic [CODE_W-1:0] start_key;
        logic [CODE_W-1:0] down_key_a;
        logic [CODE_W-1:0] down_key_b;
        logic [CODE_W-1:0] up_key_a;
        logic [CODE_W-1:0] up_key_b;
    } key_map_t;

    typedef struct packed {
        logic              is_key;
        logic [CODE_W-1:0] key_code;
        logic [1:0]        key_value;
    } key_word_t;

    typedef struct packed {
        logic [HELD_W-1:0]   held_count;
        logic                select_held;
        logic                start_held;
        logic                start_alone;
        logic                repeat_phase;
        logic [VOL_W-1:0]    volume;
        logic [BRIGHT_W-1:0] brightness;
    } hk_state_t;

    typedef struct packed {
        logic                accepted;
        logic [VOL_W-1:0]    volume_level;
        logic [BRIGHT_W-1:0] brightness_level;
        logic                volume_changed;
        logic                brightness_changed;
        logic                start_alone;
    } status_word_t;

endpackage

// ===== hw/rtl/hklc_key_if.sv =====
// Key event channel: valid/ready handshake with the event fields.
`timescale 1ns / 1ps

interface hklc_key_if import hklc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              is_key;
    logic [CODE_W-1:0] key_code;
    logic [1:0]        key_value;

    modport source (output valid, output is_key, output key_code, output key_value,
                    input ready);
    modport sink   (input valid, input is_key, input key_code, input key_value,
                    output ready);
endinterface

// ===== hw/rtl/hklc_status_if.sv =====
// Level status channel: valid/ready handshake with the result fields.
`timescale 1ns / 1ps

interface hklc_status_if import hklc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                accepted;
    logic [VOL_W-1:0]    volume_level;
    logic [BRIGHT_W-1:0] brightness_level;
    logic                volume_changed;
    logic                brightness_changed;
    logic                start_alone;

    modport source (output valid, output accepted, output volume_level,
                    output brightness_level, output volume_changed,
                    output brightness_changed, output start_alone, input ready);
    modport sink   (input valid, input accepted, input volume_level,
                    input brightness_level, input volume_changed,
                    input brightness_changed, input start_alone, output ready);
endinterface

// ===== hw/rtl/hotkey_level_controller.sv =====
// Top level of the hotkey level controller: registers, handshake and config port.
`timescale 1ns / 1ps

// Usage
//   keys   : sink channel of key event words (is_key, key_code, key_value).
//   status : source channel, one status word per key event word, in order:
//            accepted flag, volume and brightness after the event, the two
//            step flags and the start-alone flag.
//   cfg_we / cfg_index / cfg_data : register writes, one per cycle. The user
//            must write them only while no event is in flight; the block
//            does not enforce this. Indexes 0-5 set the key codes, 6 and 7
//            load the volume and brightness (clamped to their max).
// Timing
//   An accepted word goes to the input register, then its status word to
//   the status register. Throughput is one word per cycle unless status.ready
//   stalls: the state update is one short pass of step logic between them.
// Reset
//   Key codes return to their defaults, the held count and flags clear,
//   volume loads 10 and brightness 5. No words are held.
// Stall
//   While status.ready is low the status word holds; the input register
//   still takes one more word, then keys.ready drops until the status
//   register drains. Nothing is dropped.
module hotkey_level_controller import hklc_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    hklc_key_if.sink              keys,
    hklc_status_if.source         status,
    input  logic                  cfg_we,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    key_map_t     key_map_reg;
    hk_state_t    state_reg;
    hk_state_t    state_next;
    key_word_t    word_reg;
    logic         word_valid_reg;
    status_word_t status_reg;
    status_word_t status_next;
    logic         status_valid_reg;
    logic         status_load;
    logic         word_take;
    key_word_t    word_in;

    logic [VOL_W-1:0]    cfg_volume;
    logic [BRIGHT_W-1:0] cfg_brightness;

    // Advance the status register when it is empty or being drained
    assign status_load = word_valid_reg && (!status_valid_reg || status.ready);
    assign keys.ready  = !word_valid_reg || status_load;
    assign word_take   = keys.valid && keys.ready;

    assign word_in.is_key    = keys.is_key;
    assign word_in.key_code  = keys.key_code;
    assign word_in.key_value = keys.key_value;

    // Clamp the level writes to their maximum
    assign cfg_volume = (cfg_data[VOL_W-1:0] > VOL_W'(VOLUME_MAX)) ?
                        VOL_W'(VOLUME_MAX) : cfg_data[VOL_W-1:0];
    assign cfg_brightness = (cfg_data[BRIGHT_W-1:0] > BRIGHT_W'(BRIGHTNESS_MAX)) ?
                            BRIGHT_W'(BRIGHTNESS_MAX) : cfg_data[BRIGHT_W-1:0];

    hklc_step u_step (
        .cur    (state_reg),
        .word   (word_reg),
        .keys   (key_map_reg),
        .nxt    (state_next),
        .status (status_next)
    );

    // Key codes and held/level state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_map_reg.select_key <= DEF_SELECT_KEY;
            key_map_reg.start_key  <= DEF_START_KEY;
            key_map_reg.down_key_a <= DEF_DOWN_KEY_A;
            key_map_reg.down_key_b <= DEF_DOWN_KEY_B;
            key_map_reg.up_key_a   <= DEF_UP_KEY_A;
            key_map_reg.up_key_b   <= DEF_UP_KEY_B;
            state_reg.held_count   <= '0;
            state_reg.select_held  <= 1'b0;
            state_reg.start_held   <= 1'b0;
            state_reg.start_alone  <= 1'b0;
            state_reg.repeat_phase <= 1'b0;
            state_reg.volume       <= VOLUME_RESET;
            state_reg.brightness   <= BRIGHTNESS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_SELECT_KEY:         key_map_reg.select_key <= cfg_data;
                REG_START_KEY:          key_map_reg.start_key  <= cfg_data;
                REG_DOWN_KEY_A:         key_map_reg.down_key_a <= cfg_data;
                REG_DOWN_KEY_B:         key_map_reg.down_key_b <= cfg_data;
                REG_UP_KEY_A:           key_map_reg.up_key_a   <= cfg_data;
                REG_UP_KEY_B:           key_map_reg.up_key_b   <= cfg_data;
                REG_INITIAL_VOLUME:     state_reg.volume       <= cfg_volume;
                REG_INITIAL_BRIGHTNESS: state_reg.brightness   <= cfg_brightness;
                default:                key_map_reg            <= key_map_reg;
            endcase
        end
        else if (status_load)
        begin
            state_reg <= state_next;
        end
    end

    // Input word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= 1'b0;
        end
        else if (keys.ready)
        begin
            word_valid_reg <= keys.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (word_take)
        begin
            word_reg <= word_in;
        end
    end

    // Status register: hold while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_valid_reg <= 1'b0;
        end
        else if (status_load)
        begin
            status_valid_reg <= 1'b1;
        end
        else if (status.ready)
        begin
            status_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (status_load)
        begin
            status_reg <= status_next;
        end
    end

    assign status.valid              = status_valid_reg;
    assign status.accepted           = status_reg.accepted;
    assign status.volume_level       = status_reg.volume_level;
    assign status.brightness_level   = status_reg.brightness_level;
    assign status.volume_changed     = status_reg.volume_changed;
    assign status.brightness_changed = status_reg.brightness_changed;
    assign status.start_alone        = status_reg.start_alone;

    // Levels stay within range
    a_levels_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.volume <= VOL_W'(VOLUME_MAX)) &&
        (state_reg.brightness <= BRIGHT_W'(BRIGHTNESS_MAX)))
        else $error("level above its maximum");

    // A step only comes from an accepted event, and never on both levels
    a_step_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        status_valid_reg && (status_reg.volume_changed || status_reg.brightness_changed)
        |-> status_reg.accepted &&
            !(status_reg.volume_changed && status_reg.brightness_changed))
        else $error("step flag without accepted event or on both levels");

    // A volume step moves the stored volume
    a_volume_step_moves: assert property (@(posedge clk) disable iff (!rst_n)
        status_load && status_next.volume_changed && !cfg_we
        |=> state_reg.volume != $past(state_reg.volume))
        else $error("volume step flag without a volume change");

    // An ignored event leaves the state alone
    a_ignored_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        status_load && !status_next.accepted && !cfg_we
        |=> $stable(state_reg))
        else $error("ignored event changed the state");

endmodule

// ===== hw/rtl/hklc_step.sv =====
// Next-state and status logic for one key event.
`timescale 1ns / 1ps

module hklc_step import hklc_pkg::*; (
    input  hk_state_t    cur,
    input  key_word_t    word,
    input  key_map_t     keys,
    output hk_state_t    nxt,
    output status_word_t status
);

    logic              valid_evt;
    logic              press;
    logic              release_evt;
    logic              repeat_evt;
    logic              is_select;
    logic              is_start;
    logic              is_down;
    logic              is_up;
    logic              eff_press;
    logic              sel_only;
    logic              st_only;
    logic              vol_step;
    logic              bri_step;
    logic [HELD_W-1:0] held_next;

    always_comb
    begin
        valid_evt   = word.is_key && (word.key_value != KV_OTHER);
        press       = (word.key_value == KV_PRESS);
        release_evt = (word.key_value == KV_RELEASE);
        repeat_evt  = (word.key_value == KV_REPEAT);

        // First match wins: select, start, then the adjust keys
        is_select = (word.key_code == keys.select_key);
        is_start  = !is_select && (word.key_code == keys.start_key);
        is_down   = !is_select && !is_start &&
                    ((word.key_code == keys.down_key_a) ||
                     (word.key_code == keys.down_key_b));
        is_up     = !is_select && !is_start &&
                    ((word.key_code == keys.up_key_a) ||
                     (word.key_code == keys.up_key_b));

        held_next = cur.held_count;
        if (press && (cur.held_count < HELD_W'(HELD_MAX)))
        begin
            held_next = cur.held_count + HELD_W'(1);
        end
        else if (release_evt && (cur.held_count != '0))
        begin
            held_next = cur.held_count - HELD_W'(1);
        end

        // Every second auto-repeat acts as a press
        eff_press = repeat_evt ? cur.repeat_phase : press;
        sel_only  = cur.select_held && !cur.start_held;
        st_only   = cur.start_held && !cur.select_held;

        nxt      = cur;
        vol_step = 1'b0;
        bri_step = 1'b0;

        if (valid_evt)
        begin
            nxt.held_count = held_next;
            if (is_select)
            begin
                if (!repeat_evt)
                begin
                    nxt.select_held = press;
                end
            end
            else if (is_start)
            begin
                if (!repeat_evt)
                begin
                    nxt.start_held  = press;
                    nxt.start_alone = press && (held_next == HELD_W'(1));
                end
            end
            else if (is_down || is_up)
            begin
                nxt.repeat_phase = repeat_evt ? !cur.repeat_phase : 1'b0;
                if (eff_press && sel_only)
                begin
                    if (is_down && (cur.volume != '0))
                    begin
                        nxt.volume = cur.volume - VOL_W'(1);
                        vol_step   = 1'b1;
                    end
                    else if (is_up && (cur.volume < VOL_W'(VOLUME_MAX)))
                    begin
                        nxt.volume = cur.volume + VOL_W'(1);
                        vol_step   = 1'b1;
                    end
                end
                else if (eff_press && st_only)
                begin
                    if (is_down && (cur.brightness != '0))
                    begin
                        nxt.brightness = cur.brightness - BRIGHT_W'(1);
                        bri_step       = 1'b1;
                    end
                    else if (is_up && (cur.brightness < BRIGHT_W'(BRIGHTNESS_MAX)))
                    begin
                        nxt.brightness = cur.brightness + BRIGHT_W'(1);
                        bri_step       = 1'b1;
                    end
                end
            end
        end

        status.accepted           = valid_evt;
        status.volume_level       = nxt.volume;
        status.brightness_level   = nxt.brightness;
        status.volume_changed     = vol_step;
        status.brightness_changed = bri_step;
        status.start_alone        = nxt.start_alone;
    end

endmodule
